/* src/hbp_pkg.sv */
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types, constants and helpers for the hybrid branch predictor.
// ----------------------------------------------------------------------------
package hbp_pkg;

  // Table and history size limits
  localparam int BIMODAL_BITS_MAX = 12;
  localparam int GSHARE_BITS_MAX  = 12;
  localparam int CHOOSER_BITS_MAX = 12;
  localparam int HISTORY_BITS_MAX = 12;

  localparam int BIMODAL_DEPTH = 1 << BIMODAL_BITS_MAX;
  localparam int GSHARE_DEPTH  = 1 << GSHARE_BITS_MAX;
  localparam int CHOOSER_DEPTH = 1 << CHOOSER_BITS_MAX;

  // Clearing sweep covers the deepest table
  localparam int CLR_BITS_AB = (BIMODAL_BITS_MAX > GSHARE_BITS_MAX) ?
                               BIMODAL_BITS_MAX : GSHARE_BITS_MAX;
  localparam int CLR_BITS    = (CLR_BITS_AB > CHOOSER_BITS_MAX) ?
                               CLR_BITS_AB : CHOOSER_BITS_MAX;

  // Width that holds any effective index or history length
  localparam int BITS_W = 5;

  localparam int CTR_W = 3;
  localparam int CHS_W = 2;

  localparam logic [CTR_W-1:0] CTR_RESET = CTR_W'(4);
  localparam logic [CTR_W-1:0] CTR_MAX   = CTR_W'(7);
  localparam logic [CHS_W-1:0] CHS_RESET = CHS_W'(1);
  localparam logic [CHS_W-1:0] CHS_MAX   = CHS_W'(3);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BIMODAL_BITS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_GSHARE_BITS  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSER_BITS = CFG_IDX_W'(4);

  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;
  localparam logic [1:0] MODE_HYBRID  = 2'd2;

  // Register reset values
  localparam logic [1:0]            RST_MODE         = MODE_HYBRID;
  localparam logic [CFG_DATA_W-1:0] RST_BIMODAL_BITS = CFG_DATA_W'(12);
  localparam logic [CFG_DATA_W-1:0] RST_GSHARE_BITS  = CFG_DATA_W'(12);
  localparam logic [CFG_DATA_W-1:0] RST_HISTORY_BITS = CFG_DATA_W'(8);
  localparam logic [CFG_DATA_W-1:0] RST_CHOOSER_BITS = CFG_DATA_W'(8);

  typedef struct packed {
    logic [31:0] branch_pc;
    logic        branch_taken;
  } in_t;

  typedef struct packed {
    logic predicted_taken;
    logic mispredicted;
    logic used_gshare;
  } out_t;

  // Zero reads as one, anything above the table limit as the limit
  function automatic logic [BITS_W-1:0] clamp_bits(logic [CFG_DATA_W-1:0] v,
                                                   logic [BITS_W-1:0]     maxv);
    logic [BITS_W-1:0] ve;
    ve = BITS_W'(v);
    if (ve == '0) begin
      return BITS_W'(1);
    end else if (ve > maxv) begin
      return maxv;
    end
    return ve;
  endfunction

  // 3-bit saturating counter step
  function automatic logic [CTR_W-1:0] ctr_train(logic [CTR_W-1:0] c, logic taken);
    logic [CTR_W-1:0] r;
    r = c;
    if (taken) begin
      if (c != CTR_MAX) r = c + CTR_W'(1);
    end else begin
      if (c != '0) r = c - CTR_W'(1);
    end
    return r;
  endfunction

endpackage

/* src/hbp_ram.sv */
// ----------------------------------------------------------------------------
// hbp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/hybrid_branch_predictor.sv */
// ----------------------------------------------------------------------------
// hybrid_branch_predictor
// Tournament predictor (bimodal + gshare + chooser) trained by resolved
// branches; one prediction result per branch.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-----------------------------------
//   in_     | in  | in_valid / in_ready  | in_data  (branch_pc, branch_taken)
//   out_    | out | out_valid / out_ready| out_data (predicted_taken,
//           |     |                      |   mispredicted, used_gshare)
//   cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One branch per cycle sustained while the output queue has room; a result
// enters the output queue after the table read and the read-modify-write of
// the counters. Back-to-back hits on the same entry are served by a
// one-deep write bypass.
// After reset the three tables are swept to their reset values, one entry per
// cycle over all 4096 entries; in_ready stays low meanwhile, cfg writes are taken.
// A 3-entry output queue absorbs out_ready stalls; apart from the sweep, in_ready
// drops only when the queue plus the item in flight would fill it.
// ----------------------------------------------------------------------------
module hybrid_branch_predictor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hbp_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hbp_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hbp_pkg::*;

  localparam int FIFO_DEPTH = 3;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 2;

  // configuration registers
  logic [1:0]            mode_r;
  logic [CFG_DATA_W-1:0] bim_bits_r, gsh_bits_r, hist_bits_r, chs_bits_r;

  // global history and clearing sweep
  logic [HISTORY_BITS_MAX-1:0] hist_r, hist_nxt;
  logic                        clr_r;
  logic [CLR_BITS-1:0]         clr_cnt_r;

  // stage 1 (read data arrives)
  logic                        s1_vld_r;
  logic                        s1_taken_r;
  logic [BIMODAL_BITS_MAX-1:0] s1_bi_r;
  logic [GSHARE_BITS_MAX-1:0]  s1_gi_r;
  logic [CHOOSER_BITS_MAX-1:0] s1_ci_r;

  // write bypass for the entry written in the previous cycle
  logic                        fb_b_vld_r, fb_g_vld_r, fb_c_vld_r;
  logic [BIMODAL_BITS_MAX-1:0] fb_b_idx_r;
  logic [GSHARE_BITS_MAX-1:0]  fb_g_idx_r;
  logic [CHOOSER_BITS_MAX-1:0] fb_c_idx_r;
  logic [CTR_W-1:0]            fb_b_dat_r, fb_g_dat_r;
  logic [CHS_W-1:0]            fb_c_dat_r;

  // output queue
  out_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  logic in_acc, out_acc;

  // stage 0 index logic
  logic [29:0]                 word;
  logic [BITS_W-1:0]           bb, gb, cb, hb;
  logic [HISTORY_BITS_MAX-1:0] hm;
  logic [BIMODAL_BITS_MAX-1:0] bi;
  logic [GSHARE_BITS_MAX-1:0]  gw, gi, hist_g;
  logic [CHOOSER_BITS_MAX-1:0] ci;

  // RAM ports
  logic                        b_wen, g_wen, c_wen;
  logic [BIMODAL_BITS_MAX-1:0] b_waddr;
  logic [GSHARE_BITS_MAX-1:0]  g_waddr;
  logic [CHOOSER_BITS_MAX-1:0] c_waddr;
  logic [CTR_W-1:0]            b_wdata, g_wdata, b_rdata, g_rdata;
  logic [CHS_W-1:0]            c_wdata, c_rdata;

  // stage 1 logic
  logic [CTR_W-1:0] b_cnt, g_cnt, b_trn, g_trn;
  logic [CHS_W-1:0] c_cnt, c_upd;
  logic             hybrid, bpred, gpred, use_g, pred, bok, gok;
  logic             s1_b_wr, s1_g_wr, s1_c_wr;
  out_t             res;
  logic [CLR_BITS:0] clr_ext;

  assign in_acc    = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign out_data  = fifo_r[rd_ptr_r];
  assign cfg_ready = 1'b1;
  assign in_ready  = !clr_r &&
                     (({1'b0, cnt_r} + {2'b00, s1_vld_r}) <= 3'(FIFO_DEPTH - 1));

  // ---------------- stage 0: indices and history ----------------
  always_comb begin
    word = in_data.branch_pc[31:2];
    bb   = clamp_bits(bim_bits_r, BITS_W'(BIMODAL_BITS_MAX));
    gb   = clamp_bits(gsh_bits_r, BITS_W'(GSHARE_BITS_MAX));
    cb   = clamp_bits(chs_bits_r, BITS_W'(CHOOSER_BITS_MAX));
    hb   = BITS_W'(hist_bits_r);
    if (hb > gb) hb = gb;
    if (hb > BITS_W'(HISTORY_BITS_MAX)) hb = BITS_W'(HISTORY_BITS_MAX);

    for (int i = 0; i < HISTORY_BITS_MAX; i++) begin
      hm[i] = hist_r[i] & (BITS_W'(i) < hb);
    end
    for (int i = 0; i < BIMODAL_BITS_MAX; i++) begin
      bi[i] = word[i] & (BITS_W'(i) < bb);
    end
    for (int i = 0; i < GSHARE_BITS_MAX; i++) begin
      gw[i] = word[i] & (BITS_W'(i) < gb);
    end
    for (int i = 0; i < CHOOSER_BITS_MAX; i++) begin
      ci[i] = word[i] & (BITS_W'(i) < cb);
    end

    // history lands in the top bits of the gshare index
    hist_g = GSHARE_BITS_MAX'(hm) << (gb - hb);
    gi     = gw ^ hist_g;

    if (hb == '0) begin
      hist_nxt = '0;
    end else begin
      hist_nxt = (hm >> 1) |
                 (HISTORY_BITS_MAX'(in_data.branch_taken) << (hb - BITS_W'(1)));
    end
  end

  // ---------------- stage 1: predict and train ----------------
  always_comb begin
    b_cnt = (fb_b_vld_r && fb_b_idx_r == s1_bi_r) ? fb_b_dat_r : b_rdata;
    g_cnt = (fb_g_vld_r && fb_g_idx_r == s1_gi_r) ? fb_g_dat_r : g_rdata;
    c_cnt = (fb_c_vld_r && fb_c_idx_r == s1_ci_r) ? fb_c_dat_r : c_rdata;

    hybrid = !(mode_r == MODE_BIMODAL || mode_r == MODE_GSHARE);
    bpred  = b_cnt[CTR_W-1];
    gpred  = g_cnt[CTR_W-1];
    if (mode_r == MODE_BIMODAL) begin
      use_g = 1'b0;
    end else if (mode_r == MODE_GSHARE) begin
      use_g = 1'b1;
    end else begin
      use_g = c_cnt[CHS_W-1];
    end
    pred = use_g ? gpred : bpred;

    b_trn = ctr_train(b_cnt, s1_taken_r);
    g_trn = ctr_train(g_cnt, s1_taken_r);

    bok = (bpred == s1_taken_r);
    gok = (gpred == s1_taken_r);
    // move toward whichever side alone was right
    c_upd = c_cnt;
    if (bok && !gok && c_cnt != '0) c_upd = c_cnt - CHS_W'(1);
    if (gok && !bok && c_cnt != CHS_MAX) c_upd = c_cnt + CHS_W'(1);

    s1_b_wr = s1_vld_r && !use_g;
    s1_g_wr = s1_vld_r && use_g;
    s1_c_wr = s1_vld_r && hybrid && (bok != gok);

    res.predicted_taken = pred;
    res.mispredicted    = pred != s1_taken_r;
    res.used_gshare     = use_g;
  end

  // table write ports: clearing sweep, else stage 1 update
  always_comb begin
    clr_ext = {1'b0, clr_cnt_r};
    if (clr_r) begin
      b_wen   = clr_ext < (CLR_BITS+1)'(BIMODAL_DEPTH);
      g_wen   = clr_ext < (CLR_BITS+1)'(GSHARE_DEPTH);
      c_wen   = clr_ext < (CLR_BITS+1)'(CHOOSER_DEPTH);
      b_waddr = clr_cnt_r[BIMODAL_BITS_MAX-1:0];
      g_waddr = clr_cnt_r[GSHARE_BITS_MAX-1:0];
      c_waddr = clr_cnt_r[CHOOSER_BITS_MAX-1:0];
      b_wdata = CTR_RESET;
      g_wdata = CTR_RESET;
      c_wdata = CHS_RESET;
    end else begin
      b_wen   = s1_b_wr;
      g_wen   = s1_g_wr;
      c_wen   = s1_c_wr;
      b_waddr = s1_bi_r;
      g_waddr = s1_gi_r;
      c_waddr = s1_ci_r;
      b_wdata = b_trn;
      g_wdata = g_trn;
      c_wdata = c_upd;
    end
  end

  hbp_ram #(.WIDTH(CTR_W), .DEPTH(BIMODAL_DEPTH)) u_bim_ram (
    .clk     (clk),
    .wr_en   (b_wen),
    .wr_addr (b_waddr),
    .wr_data (b_wdata),
    .rd_en   (in_acc),
    .rd_addr (bi),
    .rd_data (b_rdata)
  );

  hbp_ram #(.WIDTH(CTR_W), .DEPTH(GSHARE_DEPTH)) u_gsh_ram (
    .clk     (clk),
    .wr_en   (g_wen),
    .wr_addr (g_waddr),
    .wr_data (g_wdata),
    .rd_en   (in_acc),
    .rd_addr (gi),
    .rd_data (g_rdata)
  );

  hbp_ram #(.WIDTH(CHS_W), .DEPTH(CHOOSER_DEPTH)) u_chs_ram (
    .clk     (clk),
    .wr_en   (c_wen),
    .wr_addr (c_waddr),
    .wr_data (c_wdata),
    .rd_en   (in_acc),
    .rd_addr (ci),
    .rd_data (c_rdata)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RST_MODE;
      bim_bits_r  <= RST_BIMODAL_BITS;
      gsh_bits_r  <= RST_GSHARE_BITS;
      hist_bits_r <= RST_HISTORY_BITS;
      chs_bits_r  <= RST_CHOOSER_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:         mode_r      <= cfg_data[1:0];
        CFG_BIMODAL_BITS: bim_bits_r  <= cfg_data;
        CFG_GSHARE_BITS:  gsh_bits_r  <= cfg_data;
        CFG_HISTORY_BITS: hist_bits_r <= cfg_data;
        CFG_CHOOSER_BITS: chs_bits_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      hist_r    <= '0;
      s1_vld_r  <= 1'b0;
      fb_b_vld_r <= 1'b0;
      fb_g_vld_r <= 1'b0;
      fb_c_vld_r <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + CLR_BITS'(1);
        if (clr_cnt_r == '1) clr_r <= 1'b0;
      end
      if (in_acc) hist_r <= hist_nxt;
      s1_vld_r   <= in_acc;
      fb_b_vld_r <= s1_b_wr;
      fb_g_vld_r <= s1_g_wr;
      fb_c_vld_r <= s1_c_wr;

      // queue: push the stage 1 result, pop on out transaction
      if (s1_vld_r) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(s1_vld_r) - CNT_W'(out_acc);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_taken_r <= in_data.branch_taken;
      s1_bi_r    <= bi;
      s1_gi_r    <= gi;
      s1_ci_r    <= ci;
    end
    fb_b_idx_r <= s1_bi_r;
    fb_g_idx_r <= s1_gi_r;
    fb_c_idx_r <= s1_ci_r;
    fb_b_dat_r <= b_trn;
    fb_g_dat_r <= g_trn;
    fb_c_dat_r <= c_upd;
    if (s1_vld_r) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

endmodule

/* src/hbp_checker.sv */
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks on the hybrid branch predictor, bound to its top level.
// ----------------------------------------------------------------------------
module hbp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input hbp_pkg::in_t                   in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input hbp_pkg::out_t                  out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [hbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [hbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hbp_pkg::*;

  // tables are being swept right after reset: no branch may enter
  a_clear_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // every transaction makes its result available on the output port
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result missing two cycles after input transaction");

  // a result only shows up as the consequence of an earlier input
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without matching input transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (.*);
